@@ sv/lfr_pkg.sv @@
package lfr_pkg;

	localparam int FRAME_W = 6;
	localparam int COUNT_W = 7;
	localparam int ACTION_W = 2;
	localparam int APB_AW = 3;
	localparam int APB_DW = 32;

	localparam logic [COUNT_W-1:0] CAPACITY_RST = 7'd64;

	// register word index, taken from paddr[2]
	localparam logic REG_CAPACITY = 1'b0;

	typedef enum logic [ACTION_W-1:0] {
		ACT_VICTIM = 2'd0,
		ACT_PIN    = 2'd1,
		ACT_UNPIN  = 2'd2,
		ACT_NONE   = 2'd3
	} action_t;

	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_EXEC = 1'b1
	} state_t;

	// broadcast from the controller to every cell
	typedef struct packed {
		logic               cmp_en;   // latch match against frame
		logic               shift_en; // close the gap where the prefix is set
		logic               append;   // cell at index count loads frame
		logic [FRAME_W-1:0] frame;
	} cell_ctl_t;

endpackage

@@ sv/lru_frame_replacer.sv @@
// LRU frame replacer: ordered chain of frame cells, oldest at cell 0.
// Result: registered at the update edge, taken in ST_EXEC when not stalled.
// Requests: taken only in ST_IDLE, one at a time: compare at accept, then
// shift/append through the cell chain; a stalled result holds the chain in ST_EXEC.
// Reset: count clears to 0, capacity to 64, no result pending; cell contents are
// left as they are.
module lru_frame_replacer #(
	parameter int MAX_FRAMES = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	// request
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [5:0] frame number, [7:6] zero
	input  logic [1:0]  s_tuser,   // [1:0] action
	// result
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [5:0] victim_frame, [12:6] count, [15:13] zero
	output logic [0:0]  m_tuser,   // [0] found
	// config
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int CNT_W = $clog2(MAX_FRAMES + 1);
	localparam int LIM_W = (CNT_W > lfr_pkg::COUNT_W) ? CNT_W : lfr_pkg::COUNT_W;
	localparam logic [LIM_W-1:0] MAX_EXT = LIM_W'(MAX_FRAMES);

	lfr_pkg::state_t  state_q, state_d;
	lfr_pkg::action_t action_q;
	logic [lfr_pkg::FRAME_W-1:0] req_frame_q;
	logic [lfr_pkg::COUNT_W-1:0] capacity_q;
	logic [CNT_W-1:0]            count_q, count_d;

	logic                         out_valid_q;
	logic                         found_q;
	logic [lfr_pkg::FRAME_W-1:0]  victim_q;
	logic [lfr_pkg::COUNT_W-1:0]  out_count_q;

	lfr_pkg::cell_ctl_t           ctl;
	logic [lfr_pkg::FRAME_W-1:0]  frames [MAX_FRAMES+1];
	logic [MAX_FRAMES:0]          prefix;

	logic accept, update, hit, room, found_d;
	logic [LIM_W-1:0] cnt_ext, cap_ext;

	assign accept   = s_tvalid && s_tready;
	assign hit      = prefix[MAX_FRAMES];
	assign cnt_ext  = LIM_W'(count_q);
	assign cap_ext  = LIM_W'(capacity_q);
	assign room     = (cnt_ext < cap_ext) && (cnt_ext < MAX_EXT);

	// chain ends: victim seeds the prefix at cell 0, last cell pulls in zero
	assign prefix[0]          = (action_q == lfr_pkg::ACT_VICTIM) && (count_q != '0);
	assign frames[MAX_FRAMES] = '0;

	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		update   = 1'b0;
		case (state_q)
			lfr_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					state_d = lfr_pkg::ST_EXEC;
				end
			end
			lfr_pkg::ST_EXEC: begin
				if (!out_valid_q || m_tready) begin
					update  = 1'b1;
					state_d = lfr_pkg::ST_IDLE;
				end
			end
			default: state_d = lfr_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		ctl.cmp_en   = accept;
		ctl.shift_en = update && ((action_q == lfr_pkg::ACT_VICTIM) ||
			(action_q == lfr_pkg::ACT_PIN));
		ctl.append   = update && (action_q == lfr_pkg::ACT_UNPIN) && !hit && room;
		ctl.frame    = (state_q == lfr_pkg::ST_EXEC) ? req_frame_q
			: s_tdata[lfr_pkg::FRAME_W-1:0];
	end

	always_comb begin
		count_d = count_q;
		found_d = 1'b0;
		case (action_q)
			lfr_pkg::ACT_VICTIM: begin
				if (count_q != '0) begin
					found_d = 1'b1;
					count_d = count_q - 1'b1;
				end
			end
			lfr_pkg::ACT_PIN: begin
				if (hit) begin
					count_d = count_q - 1'b1;
				end
			end
			lfr_pkg::ACT_UNPIN: begin
				if (!hit && room) begin
					count_d = count_q + 1'b1;
				end
			end
			default: count_d = count_q;
		endcase
	end

	genvar gi;
	generate
		for (gi = 0; gi < MAX_FRAMES; gi++) begin : g_cell
			lfr_cell #(
				.IDX   (gi),
				.CNT_W (CNT_W)
			) u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.ctl        (ctl),
				.count      (count_q),
				.next_frame (frames[gi+1]),
				.prefix_in  (prefix[gi]),
				.frame      (frames[gi]),
				.prefix_out (prefix[gi+1])
			);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lfr_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			action_q    <= lfr_pkg::ACT_NONE;
			req_frame_q <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				action_q    <= lfr_pkg::action_t'(s_tuser);
				req_frame_q <= s_tdata[lfr_pkg::FRAME_W-1:0];
			end
			if (update) begin
				count_q     <= count_d;
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (update) begin
			found_q     <= found_d;
			victim_q    <= found_d ? frames[0] : '0;
			out_count_q <= lfr_pkg::COUNT_W'(count_d);
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = found_q;
	assign m_tdata  = {3'b000, out_count_q, victim_q};

	// config
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= lfr_pkg::CAPACITY_RST;
		end else if (psel && penable && pwrite && pready &&
			(paddr[2] == lfr_pkg::REG_CAPACITY)) begin
			capacity_q <= pwdata[lfr_pkg::COUNT_W-1:0];
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr[2] == lfr_pkg::REG_CAPACITY)
		? {{(lfr_pkg::APB_DW - lfr_pkg::COUNT_W){1'b0}}, capacity_q} : '0;

endmodule

@@ sv/lfr_cell.sv @@
module lfr_cell #(
	parameter int IDX   = 0,
	parameter int CNT_W = 7
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  lfr_pkg::cell_ctl_t          ctl,
	input  logic [CNT_W-1:0]            count,
	input  logic [lfr_pkg::FRAME_W-1:0] next_frame,
	input  logic                        prefix_in,
	output logic [lfr_pkg::FRAME_W-1:0] frame,
	output logic                        prefix_out
);

	logic [lfr_pkg::FRAME_W-1:0] frame_q;
	logic                        match_q;
	logic                        in_use;

	assign in_use     = CNT_W'(IDX) < count;
	assign prefix_out = prefix_in | match_q;
	assign frame      = frame_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q <= 1'b0;
		end else if (ctl.cmp_en) begin
			match_q <= in_use && (frame_q == ctl.frame);
		end
	end

	// payload, no reset; entries at or past count are never looked at
	always_ff @(posedge clk) begin
		if (ctl.shift_en && prefix_out) begin
			frame_q <= next_frame;
		end else if (ctl.append && (count == CNT_W'(IDX))) begin
			frame_q <= ctl.frame;
		end
	end

endmodule
